// ----- rtl/tdil_pkg.sv -----
// Shared types and constants of the 3x3 threshold dilation block.
`default_nettype none
package tdil_pkg;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 16;
    localparam int OCOL_W     = 10;
    localparam int THR_W      = 4;
    localparam int COLS_REG_W = 11;
    localparam int CNT8_W     = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int M_DATA_W   = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SET_VALUE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 4'd3;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Per-item bookkeeping carried along with the pixel data.
    typedef struct packed {
        logic              res;
        logic              interior;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
    } t_meta;

endpackage
`default_nettype wire

// ----- rtl/tdil_ram.sv -----
// Generic single-port-write, registered-read RAM (read returns the old value on a collision).
`default_nettype none
module tdil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/threshold_dilation_3x3_top.sv -----
// Top level of the streaming 3x3 threshold dilation with two line-store RAMs.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  s_       | in        | s_tvalid / s_tready  | tdata: pixel_in; tuser: action
//  m_       | out       | m_tvalid / m_tready  | tdata: pixel_out,out_row,out_col; tlast
//  cfg      | in        | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// One request per clock sustained while m_ does not stall.
// Stage 0 reads both line stores and keeps the row/column counters, stage 1 shifts
// the window and writes the upper store, stage 2 counts neighbours into the output register.
// A stall on m_ holds every stage; s_tready drops only while the output register is full
// and not taken. Synchronous active-low reset clears control state; line stores need none.
`default_nettype none
module threshold_dilation_3x3_top
    import tdil_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [PIX_W-1:0]      s_tdata,   // [15:0] pixel_in
    input  wire logic [0:0]            s_tuser,   // [0] action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // [15:0] pixel_out, [31:16] out_row,
                                                  // [41:32] out_col, [47:42] zero
    output logic                       m_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_COLS);
    localparam int CNT_W = AW + 1;
    localparam int CMP_W = (CNT_W > COLS_REG_W) ? CNT_W : COLS_REG_W;
    localparam int IPR_W = ROW_W + 1;

    // Configuration
    logic [PIX_W-1:0]      r_set_value;
    logic [THR_W-1:0]      r_thresh;
    logic [ROW_W-1:0]      r_image_rows;
    logic [COLS_REG_W-1:0] r_image_cols;
    logic                  cfg_we;
    logic                  cfg_size;

    // Positions
    logic [IPR_W-1:0] r_ip_row, n_ip_row;
    logic [AW-1:0]    r_ip_col, n_ip_col;
    logic [ROW_W-1:0] r_op_row, n_op_row;
    logic [AW-1:0]    r_op_col, n_op_col;

    logic [ROW_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;

    logic adv, accept, feed, drain, in_done, out_ready;
    logic [PIX_W-1:0] pix0;
    t_meta            meta0;

    // Pipeline
    logic             r_s1_v;
    t_meta            r_s1_meta;
    logic [PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]    r_s1_addr;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_d;
    logic             r_s2_v;
    t_meta            r_s2_meta;

    logic [PIX_W-1:0] upper_q, mid_q, upper_new;
    logic [PIX_W-1:0] r_win [3][3];
    logic             s1_go;

    logic             r_ov;
    logic [PIX_W-1:0] r_o_pix;
    logic [ROW_W-1:0] r_o_row;
    logic [OCOL_W-1:0] r_o_col;
    logic             r_o_last;

    logic [CNT8_W-1:0] match_cnt;
    logic [PIX_W-1:0]  res_pix;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_size    = cfg_we && (i_cfg_index == REG_IMAGE_ROWS ||
                                    i_cfg_index == REG_IMAGE_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_value  <= PIX_W'(1);
            r_thresh     <= THR_W'(1);
            r_image_rows <= ROW_W'(5);
            r_image_cols <= COLS_REG_W'(5);
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_SET_VALUE:  r_set_value  <= i_cfg_data;
                REG_THRESHOLD:  r_thresh     <= i_cfg_data[THR_W-1:0];
                REG_IMAGE_ROWS: r_image_rows <= i_cfg_data[ROW_W-1:0];
                REG_IMAGE_COLS: r_image_cols <= i_cfg_data[COLS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff = (r_image_rows == '0) ? ROW_W'(1) : r_image_rows;
        if (r_image_cols == '0) begin
            cols_eff = CNT_W'(1);
        end else if (CMP_W'(r_image_cols) > CMP_W'(MAX_COLS)) begin
            cols_eff = CNT_W'(MAX_COLS);
        end else begin
            cols_eff = CNT_W'(r_image_cols);
        end
    end

    // Stage 0: decide, count positions, read line stores
    assign adv      = !r_ov || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign drain    = (s_tuser[0] == ACT_DRAIN);
    assign in_done  = r_ip_row >= IPR_W'(rows_eff);
    assign feed     = accept && (drain == in_done);
    assign pix0     = drain ? '0 : s_tdata;

    always_comb begin
        n_ip_row = r_ip_row;
        n_ip_col = r_ip_col;
        n_op_row = r_op_row;
        n_op_col = r_op_col;
        out_ready = (r_ip_row > IPR_W'(1)) ||
                    (r_ip_row == IPR_W'(1) && r_ip_col != '0);
        meta0.res      = out_ready;
        meta0.row      = r_op_row;
        meta0.col      = OCOL_W'(r_op_col);
        meta0.interior = (r_op_row != '0) &&
                         (IPR_W'(r_op_row) + IPR_W'(2) <= IPR_W'(rows_eff)) &&
                         (r_op_col != '0) &&
                         (CNT_W'(r_op_col) + CNT_W'(2) <= cols_eff);
        meta0.last     = (IPR_W'(r_op_row) + IPR_W'(1) >= IPR_W'(rows_eff)) &&
                         (CNT_W'(r_op_col) + CNT_W'(1) >= cols_eff);
        if (cfg_size) begin
            n_ip_row = '0;
            n_ip_col = '0;
            n_op_row = '0;
            n_op_col = '0;
        end else if (feed) begin
            if (CNT_W'(r_ip_col) + CNT_W'(1) >= cols_eff) begin
                n_ip_col = '0;
                n_ip_row = r_ip_row + IPR_W'(1);
            end else begin
                n_ip_col = r_ip_col + AW'(1);
            end
            if (out_ready) begin
                if (meta0.last) begin
                    n_ip_row = '0;
                    n_ip_col = '0;
                    n_op_row = '0;
                    n_op_col = '0;
                end else if (CNT_W'(r_op_col) + CNT_W'(1) >= cols_eff) begin
                    n_op_col = '0;
                    n_op_row = r_op_row + ROW_W'(1);
                end else begin
                    n_op_col = r_op_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_row <= '0;
            r_ip_col <= '0;
            r_op_row <= '0;
            r_op_col <= '0;
        end else begin
            r_ip_row <= n_ip_row;
            r_ip_col <= n_ip_col;
            r_op_row <= n_op_row;
            r_op_col <= n_op_col;
        end
    end

    assign s1_go = adv && r_s1_v;

    tdil_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (feed),
        .i_waddr (r_ip_col),
        .i_wdata (pix0),
        .i_re    (feed),
        .i_raddr (r_ip_col),
        .o_rdata (mid_q)
    );

    // Upper row takes the old middle row when that item advances out of stage 1 (s1_go).
    tdil_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (mid_q),
        .i_re    (feed),
        .i_raddr (r_ip_col),
        .o_rdata (upper_q)
    );

    assign upper_new = r_fwd ? r_fwd_d : upper_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= feed;
            // Forward an upper-store write that collides with this read.
            r_fwd  <= feed && r_s1_v && (r_s1_addr == r_ip_col);
            r_s2_v <= r_s1_v && r_s1_meta.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (feed) begin
                r_s1_meta <= meta0;
                r_s1_pix  <= pix0;
                r_s1_addr <= r_ip_col;
                r_fwd_d   <= mid_q;
            end
            r_s2_meta <= r_s1_meta;
        end
    end

    // Stage 1: shift window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (s1_go) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= upper_new;
            r_win[1][2] <= mid_q;
            r_win[2][2] <= r_s1_pix;
        end
    end

    // Stage 2: neighbour count and result
    always_comb begin
        match_cnt = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (!(r == 1 && k == 1) && r_win[r][k] == r_set_value) begin
                    match_cnt = match_cnt + CNT8_W'(1);
                end
            end
        end
        res_pix = r_win[1][1];
        if (r_win[1][1] == '0 && r_s2_meta.interior && match_cnt > r_thresh) begin
            res_pix = r_set_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_v) begin
            r_o_pix  <= res_pix;
            r_o_row  <= r_s2_meta.row;
            r_o_col  <= r_s2_meta.col;
            r_o_last <= r_s2_meta.last;
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {{(M_DATA_W - PIX_W - ROW_W - OCOL_W){1'b0}}, r_o_col, r_o_row, r_o_pix};
    assign m_tlast  = r_o_last;

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_v)
        else $error("forwarded upper data without an item in stage 1");

    a_res_needs_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_v) |-> $past(adv) || $past(r_s2_v))
        else $error("stage 2 result appeared without advance");

    a_cols_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_ip_col) < cols_eff) && (CNT_W'(r_op_col) < cols_eff))
        else $error("column counter beyond frame width");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (feed && out_ready && meta0.last) |=> (r_ip_row == '0 && r_op_row == '0))
        else $error("frame end did not restart positions");

    a_stall_holds_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_win[1][1]) && $stable(r_s2_v))
        else $error("pipeline moved during output stall");

endmodule
`default_nettype wire
